FILE: hw/rtl/pkhp_pkg.sv
// shared types, constants and helpers for the frame header parser
// no dependencies
`timescale 1ns / 1ps

package pkhp_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 16384;
    localparam int MAX_RES = 4;
    localparam int RES_DEPTH = 8;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_last;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  field_code;
        logic [47:0] field_value;
        logic        run_last;
    } out_item_t;

    typedef struct packed {
        logic [2:0]               n;
        out_item_t [MAX_RES-1:0]  item;
    } res_set_t;

    typedef enum logic [6:0] {
        LY_ETH  = 7'b0000001,
        LY_ARP  = 7'b0000010,
        LY_IP   = 7'b0000100,
        LY_ICMP = 7'b0001000,
        LY_TCP  = 7'b0010000,
        LY_UDP  = 7'b0100000,
        LY_IDLE = 7'b1000000
    } layer_t;

    localparam logic [4:0] FC_DMAC = 5'd0, FC_SMAC = 5'd1, FC_ETYPE = 5'd2;
    localparam logic [4:0] FC_ARP_OP = 5'd3, FC_ARP_SMAC = 5'd4, FC_ARP_SIP = 5'd5;
    localparam logic [4:0] FC_ARP_TMAC = 5'd6, FC_ARP_TIP = 5'd7;
    localparam logic [4:0] FC_IP_VER = 5'd8, FC_IP_HLEN = 5'd9, FC_IP_TLEN = 5'd10;
    localparam logic [4:0] FC_IP_TTL = 5'd11, FC_IP_PROTO = 5'd12, FC_IP_CSUM = 5'd13;
    localparam logic [4:0] FC_IP_SRC = 5'd14, FC_IP_DST = 5'd15, FC_IP_OK = 5'd16;
    localparam logic [4:0] FC_TCP_SPORT = 5'd17, FC_TCP_DPORT = 5'd18;
    localparam logic [4:0] FC_TCP_SEQ = 5'd19, FC_TCP_ACK = 5'd20, FC_TCP_FLAGS = 5'd21;
    localparam logic [4:0] FC_TCP_WIN = 5'd22, FC_TCP_CSUM = 5'd23, FC_TCP_OK = 5'd24;
    localparam logic [4:0] FC_ICMP_TYPE = 5'd25, FC_UDP_SPORT = 5'd26;
    localparam logic [4:0] FC_UDP_DPORT = 5'd27, FC_FRAME_END = 5'd28;

    localparam logic [15:0] ETYPE_ARP = 16'h0806;
    localparam logic [15:0] ETYPE_IP  = 16'h0800;
    localparam logic [7:0]  PROTO_ICMP = 8'd1;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [7:0]  TCP_FLAG_MASK = 8'h17;

    // ones' complement 16-bit add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] s, input logic [15:0] w);
        logic [16:0] t;
        logic [16:0] u;
        t = {1'b0, s} + {1'b0, w};
        u = {1'b0, t[15:0]} + {16'd0, t[16]};
        return u[15:0];
    endfunction

    function automatic res_set_t res_push(input res_set_t s, input logic [4:0] code,
                                          input logic [47:0] val);
        res_set_t r;
        r = s;
        if (s.n < 3'(MAX_RES)) begin
            r.item[s.n[1:0]].field_code  = code;
            r.item[s.n[1:0]].field_value = val;
            r.item[s.n[1:0]].run_last    = 1'b0;
            r.n = s.n + 3'd1;
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/pkhp_parse.sv
// per-byte header parse state and checksum accumulation
// depends on pkhp_pkg
`timescale 1ns / 1ps

module pkhp_parse
    import pkhp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     take,
    input  in_item_t req,
    output res_set_t res
);

    logic [15:0] pos_reg, pos_next;
    layer_t      layer_reg, layer_next;
    logic [47:0] shift_reg, shift_next;
    logic [5:0]  ihb_reg, ihb_next;
    logic [15:0] tlen_reg, tlen_next;
    logic [7:0]  proto_reg, proto_next;
    logic [15:0] ipsum_reg, ipsum_next;
    logic [15:0] tcpsum_reg, tcpsum_next;
    logic [15:0] left_reg, left_next;
    logic [8:0]  hold_reg, hold_next;

    always_comb
    begin
        logic [7:0]  b;
        logic [15:0] off;
        logic [15:0] w;
        logic        have_w;
        logic [15:0] seg;
        res_set_t    r;
        b = req.frame_byte;
        r = '0;
        off = '0;
        w = '0;
        have_w = 1'b0;
        seg = '0;
        pos_next = pos_reg;
        layer_next = layer_reg;
        shift_next = shift_reg;
        ihb_next = ihb_reg;
        tlen_next = tlen_reg;
        proto_next = proto_reg;
        ipsum_next = ipsum_reg;
        tcpsum_next = tcpsum_reg;
        left_next = left_reg;
        hold_next = hold_reg;

        if (pos_reg < 16'(MAX_FRAME_BYTES)) begin
            shift_next = {shift_reg[39:0], b};
            unique case (layer_reg)
                LY_ETH:
                begin
                    if (pos_reg == 16'd5)
                        r = res_push(r, FC_DMAC, shift_next);
                    else if (pos_reg == 16'd11)
                        r = res_push(r, FC_SMAC, shift_next);
                    else if (pos_reg == 16'd13) begin
                        r = res_push(r, FC_ETYPE, {32'd0, shift_next[15:0]});
                        if (shift_next[15:0] == ETYPE_ARP)
                            layer_next = LY_ARP;
                        else if (shift_next[15:0] == ETYPE_IP)
                            layer_next = LY_IP;
                        else
                            layer_next = LY_IDLE;
                    end
                end
                LY_ARP:
                begin
                    off = pos_reg - 16'd14;
                    if (off == 16'd7)
                        r = res_push(r, FC_ARP_OP, {32'd0, shift_next[15:0]});
                    else if (off == 16'd13)
                        r = res_push(r, FC_ARP_SMAC, shift_next);
                    else if (off == 16'd17)
                        r = res_push(r, FC_ARP_SIP, {16'd0, shift_next[31:0]});
                    else if (off == 16'd23)
                        r = res_push(r, FC_ARP_TMAC, shift_next);
                    else if (off == 16'd27) begin
                        r = res_push(r, FC_ARP_TIP, {16'd0, shift_next[31:0]});
                        layer_next = LY_IDLE;
                    end
                end
                LY_IP:
                begin
                    off = pos_reg - 16'd14;
                    if (off == 16'd0) begin
                        ihb_next = {b[3:0], 2'b00};
                        r = res_push(r, FC_IP_VER, {44'd0, b[7:4]});
                        r = res_push(r, FC_IP_HLEN, {42'd0, ihb_next});
                    end else if (off == 16'd3) begin
                        tlen_next = shift_next[15:0];
                        r = res_push(r, FC_IP_TLEN, {32'd0, tlen_next});
                    end else if (off == 16'd8)
                        r = res_push(r, FC_IP_TTL, {40'd0, b});
                    else if (off == 16'd9) begin
                        proto_next = b;
                        r = res_push(r, FC_IP_PROTO, {40'd0, b});
                    end else if (off == 16'd11)
                        r = res_push(r, FC_IP_CSUM, {32'd0, shift_next[15:0]});
                    else if (off == 16'd15)
                        r = res_push(r, FC_IP_SRC, {16'd0, shift_next[31:0]});
                    else if (off == 16'd19)
                        r = res_push(r, FC_IP_DST, {16'd0, shift_next[31:0]});

                    // pair bytes into big-endian words
                    if (hold_reg[8]) begin
                        w = {hold_reg[7:0], b};
                        have_w = 1'b1;
                        hold_next = '0;
                    end else begin
                        hold_next = {1'b1, b};
                    end
                    if (have_w) begin
                        if (off < {10'd0, ihb_next})
                            ipsum_next = oc_add(ipsum_reg, w);
                        if (off >= 16'd12 && off <= 16'd19)
                            tcpsum_next = oc_add(tcpsum_reg, w);
                    end

                    if (ihb_next < 6'd20) begin
                        if (off == 16'd19) begin
                            r = res_push(r, FC_IP_OK, 48'd0);
                            layer_next = LY_IDLE;
                        end
                    end else if (off == {10'd0, ihb_next - 6'd1}) begin
                        r = res_push(r, FC_IP_OK, {47'd0, ipsum_next == 16'hFFFF});
                        hold_next = '0;
                        if (proto_next == PROTO_ICMP)
                            layer_next = LY_ICMP;
                        else if (proto_next == PROTO_TCP) begin
                            seg = (tlen_next > {10'd0, ihb_next}) ?
                                  tlen_next - {10'd0, ihb_next} : 16'd0;
                            tcpsum_next = oc_add(oc_add(tcpsum_next, {8'd0, proto_next}),
                                                 seg);
                            left_next = seg;
                            layer_next = LY_TCP;
                            if (seg == 16'd0)
                                r = res_push(r, FC_TCP_OK,
                                             {47'd0, tcpsum_next == 16'hFFFF});
                        end else if (proto_next == PROTO_UDP)
                            layer_next = LY_UDP;
                        else
                            layer_next = LY_IDLE;
                    end
                end
                LY_ICMP:
                begin
                    r = res_push(r, FC_ICMP_TYPE, {40'd0, b});
                    layer_next = LY_IDLE;
                end
                LY_UDP:
                begin
                    off = pos_reg - 16'd14 - {10'd0, ihb_reg};
                    if (off == 16'd1)
                        r = res_push(r, FC_UDP_SPORT, {32'd0, shift_next[15:0]});
                    else if (off == 16'd3) begin
                        r = res_push(r, FC_UDP_DPORT, {32'd0, shift_next[15:0]});
                        layer_next = LY_IDLE;
                    end
                end
                LY_TCP:
                begin
                    off = pos_reg - 16'd14 - {10'd0, ihb_reg};
                    if (off == 16'd1)
                        r = res_push(r, FC_TCP_SPORT, {32'd0, shift_next[15:0]});
                    else if (off == 16'd3)
                        r = res_push(r, FC_TCP_DPORT, {32'd0, shift_next[15:0]});
                    else if (off == 16'd7)
                        r = res_push(r, FC_TCP_SEQ, {16'd0, shift_next[31:0]});
                    else if (off == 16'd11)
                        r = res_push(r, FC_TCP_ACK, {16'd0, shift_next[31:0]});
                    else if (off == 16'd13)
                        r = res_push(r, FC_TCP_FLAGS, {40'd0, b & TCP_FLAG_MASK});
                    else if (off == 16'd15)
                        r = res_push(r, FC_TCP_WIN, {32'd0, shift_next[15:0]});
                    else if (off == 16'd17)
                        r = res_push(r, FC_TCP_CSUM, {32'd0, shift_next[15:0]});
                    if (left_reg != 16'd0) begin
                        if (hold_reg[8]) begin
                            tcpsum_next = oc_add(tcpsum_reg, {hold_reg[7:0], b});
                            hold_next = '0;
                        end else begin
                            hold_next = {1'b1, b};
                        end
                        left_next = left_reg - 16'd1;
                        if (left_next == 16'd0) begin
                            // odd final byte padded with zero
                            if (hold_next[8]) begin
                                tcpsum_next = oc_add(tcpsum_next, {hold_next[7:0], 8'd0});
                                hold_next = '0;
                            end
                            r = res_push(r, FC_TCP_OK, {47'd0, tcpsum_next == 16'hFFFF});
                        end
                    end
                    if (off >= 16'd17 && left_next == 16'd0)
                        layer_next = LY_IDLE;
                end
                LY_IDLE:
                begin
                    layer_next = LY_IDLE;
                end
                default:
                begin
                    layer_next = LY_IDLE;
                end
            endcase
        end

        if (pos_reg != 16'hFFFF)
            pos_next = pos_reg + 16'd1;

        if (req.frame_last) begin
            r = res_push(r, FC_FRAME_END, {32'd0, pos_next});
            pos_next = '0;
            layer_next = LY_ETH;
            shift_next = '0;
            ihb_next = '0;
            tlen_next = '0;
            proto_next = '0;
            ipsum_next = '0;
            tcpsum_next = '0;
            left_next = '0;
            hold_next = '0;
        end

        if (r.n != 3'd0)
            r.item[2'(r.n - 3'd1)].run_last = 1'b1;
        res = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg    <= '0;
            layer_reg  <= LY_ETH;
            shift_reg  <= '0;
            ihb_reg    <= '0;
            tlen_reg   <= '0;
            proto_reg  <= '0;
            ipsum_reg  <= '0;
            tcpsum_reg <= '0;
            left_reg   <= '0;
            hold_reg   <= '0;
        end else if (take) begin
            pos_reg    <= pos_next;
            layer_reg  <= layer_next;
            shift_reg  <= shift_next;
            ihb_reg    <= ihb_next;
            tlen_reg   <= tlen_next;
            proto_reg  <= proto_next;
            ipsum_reg  <= ipsum_next;
            tcpsum_reg <= tcpsum_next;
            left_reg   <= left_next;
            hold_reg   <= hold_next;
        end
    end

    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        take && req.frame_last |=> pos_reg == 16'd0 && layer_reg == LY_ETH)
        else $error("frame end did not return parser to start");

    a_res_nonzero_end: assert property (@(posedge clk) disable iff (!rst_n)
        take && req.frame_last |-> res.n != 3'd0)
        else $error("frame end produced no result");

    a_hold_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        layer_reg == LY_ETH |-> hold_reg == 9'd0 && left_reg == 16'd0)
        else $error("stale checksum state in ethernet layer");

endmodule

FILE: hw/rtl/packet_header_parser_checksum_core.sv
// top level: frame byte parser with result queue
// depends on pkhp_pkg and pkhp_parse
`timescale 1ns / 1ps

// Ethernet/ARP/IPv4/ICMP/UDP/TCP header parser with IPv4 and TCP checksum check.
// Input channel: one frame byte per request (in_valid, in_stall, in_data), with
// frame_last on the final byte. Output channel: one result per request
// (out_valid, out_stall, out_data) carrying field_code, field_value and
// run_last, set on the last result caused by one input byte.
// Each byte is parsed in the cycle it is taken; its zero to four results are
// written into an eight-entry result queue and show on the output once the
// results ahead of them are taken. Throughput is one byte per cycle while the
// receiver takes results; in_stall rises when fewer than four queue entries
// are free, so a run of multi-result bytes is limited by the output rate of
// one result per cycle.
// Reset clears the parse state and empties the queue; the block is ready to
// take a byte as soon as reset is released. A stalled receiver holds the head
// result steady and stalls the input once fewer than four queue entries are free.
module packet_header_parser_checksum_core
    import pkhp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    localparam int PW = $clog2(RES_DEPTH);

    out_item_t      q_mem [RES_DEPTH];
    logic [PW-1:0]  wr_reg, rd_reg;
    logic [PW:0]    cnt_reg, cnt_next;
    logic           take, pop;
    logic [2:0]     push_n;
    res_set_t       res;

    assign in_stall = cnt_reg > (PW+1)'(RES_DEPTH - MAX_RES);
    assign take     = in_valid && !in_stall;
    assign out_valid = cnt_reg != '0;
    assign pop      = out_valid && !out_stall;
    assign out_data = q_mem[rd_reg];
    assign push_n   = take ? res.n : 3'd0;
    assign cnt_next = cnt_reg + (PW+1)'(push_n) - (PW+1)'(pop);

    pkhp_parse #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_parse (
        .clk  (clk),
        .rst_n(rst_n),
        .take (take),
        .req  (in_data),
        .res  (res)
    );

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RES; i++) begin
            if (take && 3'(i) < res.n)
                q_mem[PW'(wr_reg + PW'(i))] <= res.item[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_reg + PW'(push_n);
            rd_reg  <= rd_reg + PW'(pop);
            cnt_reg <= cnt_next;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (PW+1)'(RES_DEPTH))
        else $error("result queue overflow");

    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> cnt_reg == $past(cnt_reg) + (PW+1)'($past(push_n)) - (PW+1)'($past(pop)))
        else $error("result queue count mismatch");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        PW'(wr_reg - rd_reg) == cnt_reg[PW-1:0])
        else $error("queue pointers disagree with count");

endmodule
